[sv/assert_macros.svh]
// Assertion helpers shared by the histogram modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define CSH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Check the consequent in the cycle after the antecedent.
`define CSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

[sv/csh_pkg.sv]
`timescale 1ns / 1ps

package csh_pkg;

	// Field widths of the request, response and register port
	localparam int SAMPLE_W    = 16;
	localparam int INDEX_W     = 8;
	localparam int COUNT_OUT_W = 32;
	localparam int ACTIVE_W    = 9;
	localparam int CFG_DATA_W  = 9;
	localparam int CFG_INDEX_W = 2;
	localparam int REQ_W       = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BASE   = 2'd2;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 9'd256;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;      // capture request fields
		logic fetch;      // read bin count into read register
		logic write_inc;  // write back saturated increment
		logic clr_write;  // zero one bin of the clear sweep
		logic clr_prev;   // forget the previous sample
		logic prev_upd;   // record the current sample as previous
		logic load_out;   // load the response register
	} csh_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic hit;        // current sample gets counted
		logic clr_last;   // sweep is at the last bin
		logic out_free;   // response register can take a new beat
	} csh_stat_t;

endpackage

[sv/csh_datapath.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csh_datapath import csh_pkg::*; #(
	parameter int NUM_BINS    = 256,
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [REQ_W-1:0]       req_type,
	input  logic [SAMPLE_W-1:0]    sample,
	input  logic [INDEX_W-1:0]     bin_index,
	input  logic                   rsp_ready,
	output logic                   rsp_valid,
	output logic [INDEX_W-1:0]     bin_number,
	output logic [COUNT_OUT_W-1:0] bin_count,
	input  csh_cmd_t               cmd,
	output csh_stat_t              status
);

	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SMP_MASK = SAMPLE_W'((33'd1 << SW) - 33'd1);
	localparam logic [31:0] BINS32 = 32'(NUM_BINS);
	localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

	logic                   mode_q;
	logic [ACTIVE_W-1:0]    active_q;
	logic [INDEX_W-1:0]     base_q;
	logic [SAMPLE_W-1:0]    smp_q;
	logic [INDEX_W-1:0]     num_q;
	logic                   idx_ok_q;
	logic [AW-1:0]          addr_q;
	logic [COUNT_BITS-1:0]  rdata_q;
	logic [SAMPLE_W-1:0]    prev_q;
	logic                   prev_valid_q;
	logic [AW-1:0]          clr_q;
	logic                   rsp_valid_q;
	logic [INDEX_W-1:0]     rsp_num_q;
	logic [COUNT_OUT_W-1:0] rsp_cnt_q;
	logic [COUNT_BITS-1:0]  mem [NUM_BINS];

	logic [SAMPLE_W-1:0]    smp_masked;
	logic [31:0]            smp_ext;
	logic [31:0]            idx_ext;
	logic [31:0]            active_ext;
	logic [31:0]            lim;
	logic                   prev_ok;
	logic [COUNT_BITS-1:0]  inc;
	logic [63:0]            cnt_ext;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			active_q <= ACTIVE_RESET;
			base_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[0];
				CFG_ACTIVE: active_q <= cfg_data[ACTIVE_W-1:0];
				CFG_BASE:   base_q   <= cfg_data[INDEX_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture request fields and the bin address
	assign smp_masked = sample & SMP_MASK;
	assign smp_ext    = 32'(smp_masked);
	assign idx_ext    = 32'(bin_index);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			smp_q    <= smp_masked;
			num_q    <= bin_index;
			idx_ok_q <= idx_ext < BINS32;
			addr_q   <= (req_type == REQ_READ) ? idx_ext[AW-1:0] : smp_ext[AW-1:0];
		end
	end

	// Decide whether the sample is counted
	assign active_ext = 32'(active_q);
	assign lim        = (active_ext < BINS32) ? active_ext : BINS32;
	assign prev_ok    = prev_valid_q && (prev_q == SAMPLE_W'(base_q)) &&
	                    (32'(prev_q) < lim);
	assign status.hit = (32'(smp_q) < lim) && (!mode_q || prev_ok);

	// Track the previous sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
		end else if (cmd.clr_prev) begin
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
		end else if (cmd.prev_upd) begin
			prev_q       <= smp_q;
			prev_valid_q <= 1'b1;
		end
	end

	// Advance the clear sweep
	assign status.clr_last = (clr_q == LAST_BIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_write) begin
			clr_q <= status.clr_last ? '0 : clr_q + AW'(1);
		end
	end

	// Bin count memory, one write and one registered read
	assign inc = (&rdata_q) ? rdata_q : rdata_q + COUNT_BITS'(1);

	always_ff @(posedge clk) begin
		if (cmd.clr_write) begin
			mem[clr_q] <= '0;
		end else if (cmd.write_inc) begin
			mem[addr_q] <= inc;
		end
		if (cmd.fetch) begin
			rdata_q <= mem[addr_q];
		end
	end

	// Response register
	assign cnt_ext         = 64'(rdata_q);
	assign status.out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_num_q <= num_q;
			rsp_cnt_q <= idx_ok_q ? cnt_ext[COUNT_OUT_W-1:0] : '0;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign bin_number = rsp_num_q;
	assign bin_count  = rsp_cnt_q;

	`CSH_ASSERT_NEXT(a_load_shows_beat, clk, arst_n, cmd.load_out, rsp_valid_q)
	`CSH_ASSERT_NEXT(a_prev_marked, clk, arst_n, cmd.prev_upd && !cmd.clr_prev, prev_valid_q)

endmodule

[sv/csh_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csh_ctrl import csh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [REQ_W-1:0] req_type,
	output logic             req_ready,
	input  csh_stat_t        status,
	output csh_cmd_t         cmd
);

	typedef enum logic [5:0] {
		ST_CLR       = 6'b000001,
		ST_IDLE      = 6'b000010,
		ST_ADD_FETCH = 6'b000100,
		ST_ADD_WRITE = 6'b001000,
		ST_RD_FETCH  = 6'b010000,
		ST_RD_LOAD   = 6'b100000
	} csh_state_t;

	csh_state_t state_q;
	csh_state_t state_d;

	// Sequence adds through fetch and update, reads through fetch and response, clears through the sweep
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_write = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					unique case (req_type)
						REQ_ADD:  state_d = ST_ADD_FETCH;
						REQ_READ: state_d = ST_RD_FETCH;
						REQ_CLEAR: begin
							cmd.clr_prev = 1'b1;
							state_d      = ST_CLR;
						end
						default: ;
					endcase
				end
			end
			ST_ADD_FETCH: begin
				cmd.fetch    = 1'b1;
				cmd.prev_upd = 1'b1;
				state_d      = status.hit ? ST_ADD_WRITE : ST_IDLE;
			end
			ST_ADD_WRITE: begin
				cmd.write_inc = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_RD_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_RD_LOAD;
			end
			ST_RD_LOAD: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Start in the clear sweep so every bin reads zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	`CSH_ASSERT_NOW(a_no_write_when_ready, clk, arst_n, req_ready, !cmd.clr_write && !cmd.write_inc)
	`CSH_ASSERT_NOW(a_load_when_free, clk, arst_n, cmd.load_out, status.out_free)

endmodule

[sv/conditional_sample_histogram.sv]
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// req       req_valid/req_ready    req_type, sample, bin_index
// rsp       rsp_valid/rsp_ready    bin_number, bin_count
// cfg       cfg_we                 cfg_index, cfg_data
//
// An add is accepted, reads its bin from memory and, only when the sample is
// counted, writes the increment back. A read is accepted, fetches the count and
// loads the response register once that is free; it holds one beat while the
// next request is accepted. A clear zeroes the bin memory one entry a cycle.
// After reset the same clear sweep runs with req_ready low.
// The bin memory read-modify-write sets the add rate; requests wait for idle.

module conditional_sample_histogram import csh_pkg::*; #(
	parameter int NUM_BINS    = 256,
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic [REQ_W-1:0]       req_type,
	input  logic [SAMPLE_W-1:0]    sample,
	input  logic [INDEX_W-1:0]     bin_index,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output logic [INDEX_W-1:0]     bin_number,
	output logic [COUNT_OUT_W-1:0] bin_count
);

	csh_cmd_t  cmd;
	csh_stat_t status;

	csh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	csh_datapath #(
		.NUM_BINS    (NUM_BINS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_type   (req_type),
		.sample     (sample),
		.bin_index  (bin_index),
		.rsp_ready  (rsp_ready),
		.rsp_valid  (rsp_valid),
		.bin_number (bin_number),
		.bin_count  (bin_count),
		.cmd        (cmd),
		.status     (status)
	);

endmodule
